@@ hdl/sphpf_pkg.sv @@
package sphpf_pkg;

    // operations of the shared arithmetic unit
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_NEG,
        OP_ABS,
        OP_MUL,
        OP_DIV
    } t_alu_op;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_FIN,
        ALU_DONE
    } t_alu_state;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_ISSUE,
        SEQ_WAIT,
        SEQ_FINISH
    } t_seq_state;

    // operand and destination registers of the sequencer
    typedef enum logic [4:0] {
        REG_SP,
        REG_SV,
        REG_SPR,
        REG_SRHO,
        REG_H,
        REG_NP,
        REG_NV,
        REG_NPR,
        REG_NRHO,
        REG_M,
        REG_D,
        REG_Q,
        REG_T,
        REG_S,
        REG_B,
        REG_POLY,
        REG_SIGMA,
        REG_G,
        REG_PS,
        REG_PN,
        REG_AT,
        REG_ET,
        REG_ACC,
        REG_EN,
        REG_ONE,
        REG_TWO,
        REG_C075,
        REG_ZERO
    } t_reg;

    typedef enum logic [5:0] {
        ST_D,
        ST_DIST,
        ST_Q,
        ST_A,
        ST_AA,
        ST_A75,
        ST_POLY,
        ST_B,
        ST_BB,
        ST_B2,
        ST_B3,
        ST_PSUM,
        ST_H2,
        ST_H3,
        ST_SIG,
        ST_SP,
        ST_SPH,
        ST_G,
        ST_SRSQ,
        ST_PS,
        ST_NRSQ,
        ST_PN,
        ST_PP,
        ST_MPP,
        ST_AT,
        ST_PSM,
        ST_VIJ,
        ST_EV,
        ST_EG,
        ST_ET,
        ST_ATN,
        ST_ETN,
        ST_ACC,
        ST_EN
    } t_step;

    typedef struct packed {
        t_alu_op op;
        t_reg    sa;
        t_reg    sb;
        t_reg    dst;
    } t_uop;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_alu_rsp;

    function automatic t_uop f_uop(t_step s);
        t_uop u;
        case (s)
            ST_D:    u = '{OP_SUB, REG_SP,    REG_NP,    REG_D};
            ST_DIST: u = '{OP_ABS, REG_D,     REG_ZERO,  REG_T};
            ST_Q:    u = '{OP_DIV, REG_T,     REG_H,     REG_Q};
            ST_A:    u = '{OP_SUB, REG_TWO,   REG_Q,     REG_T};
            ST_AA:   u = '{OP_MUL, REG_T,     REG_T,     REG_T};
            ST_A75:  u = '{OP_MUL, REG_T,     REG_C075,  REG_T};
            ST_POLY: u = '{OP_NEG, REG_T,     REG_ZERO,  REG_POLY};
            ST_B:    u = '{OP_SUB, REG_ONE,   REG_Q,     REG_B};
            ST_BB:   u = '{OP_MUL, REG_B,     REG_B,     REG_B};
            ST_B2:   u = '{OP_ADD, REG_B,     REG_B,     REG_S};
            ST_B3:   u = '{OP_ADD, REG_B,     REG_S,     REG_S};
            ST_PSUM: u = '{OP_ADD, REG_POLY,  REG_S,     REG_POLY};
            ST_H2:   u = '{OP_ADD, REG_H,     REG_H,     REG_S};
            ST_H3:   u = '{OP_ADD, REG_H,     REG_S,     REG_S};
            ST_SIG:  u = '{OP_DIV, REG_TWO,   REG_S,     REG_SIGMA};
            ST_SP:   u = '{OP_MUL, REG_SIGMA, REG_POLY,  REG_T};
            ST_SPH:  u = '{OP_DIV, REG_T,     REG_H,     REG_T};
            ST_G:    u = '{OP_NEG, REG_T,     REG_ZERO,  REG_G};
            ST_SRSQ: u = '{OP_MUL, REG_SRHO,  REG_SRHO,  REG_T};
            ST_PS:   u = '{OP_DIV, REG_SPR,   REG_T,     REG_PS};
            ST_NRSQ: u = '{OP_MUL, REG_NRHO,  REG_NRHO,  REG_T};
            ST_PN:   u = '{OP_DIV, REG_NPR,   REG_T,     REG_PN};
            ST_PP:   u = '{OP_ADD, REG_PS,    REG_PN,    REG_T};
            ST_MPP:  u = '{OP_MUL, REG_M,     REG_T,     REG_T};
            ST_AT:   u = '{OP_MUL, REG_T,     REG_G,     REG_AT};
            ST_PSM:  u = '{OP_MUL, REG_PS,    REG_M,     REG_T};
            ST_VIJ:  u = '{OP_SUB, REG_SV,    REG_NV,    REG_S};
            ST_EV:   u = '{OP_MUL, REG_T,     REG_S,     REG_T};
            ST_EG:   u = '{OP_MUL, REG_T,     REG_G,     REG_T};
            ST_ET:   u = '{OP_NEG, REG_T,     REG_ZERO,  REG_ET};
            ST_ATN:  u = '{OP_NEG, REG_AT,    REG_ZERO,  REG_AT};
            ST_ETN:  u = '{OP_NEG, REG_ET,    REG_ZERO,  REG_ET};
            ST_ACC:  u = '{OP_ADD, REG_ACC,   REG_AT,    REG_ACC};
            ST_EN:   u = '{OP_ADD, REG_EN,    REG_ET,    REG_EN};
            default: u = '{OP_ADD, REG_ZERO,  REG_ZERO,  REG_ZERO};
        endcase
        return u;
    endfunction

endpackage

@@ hdl/sphpf_if.sv @@
interface sphpf_pair_if #(
    parameter int WORD_WIDTH = 48
);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] src_position;
    logic signed [WORD_WIDTH-1:0] src_velocity;
    logic        [WORD_WIDTH-2:0] src_pressure;
    logic        [WORD_WIDTH-2:0] src_density;
    logic        [WORD_WIDTH-2:0] smoothing_length;
    logic signed [WORD_WIDTH-1:0] nbr_position;
    logic signed [WORD_WIDTH-1:0] nbr_velocity;
    logic        [WORD_WIDTH-2:0] nbr_pressure;
    logic        [WORD_WIDTH-2:0] nbr_density;
    logic        [WORD_WIDTH-2:0] nbr_mass;
    logic                         last_pair;

    modport source (
        output valid, src_position, src_velocity, src_pressure, src_density,
               smoothing_length, nbr_position, nbr_velocity, nbr_pressure,
               nbr_density, nbr_mass, last_pair,
        input  ready
    );
    modport sink (
        input  valid, src_position, src_velocity, src_pressure, src_density,
               smoothing_length, nbr_position, nbr_velocity, nbr_pressure,
               nbr_density, nbr_mass, last_pair,
        output ready
    );
endinterface

interface sphpf_sum_if #(
    parameter int WORD_WIDTH = 48
);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] acceleration;
    logic signed [WORD_WIDTH-1:0] energy_rate;
    logic                         saturated;

    modport source (
        output valid, acceleration, energy_rate, saturated,
        input  ready
    );
    modport sink (
        input  valid, acceleration, energy_rate, saturated,
        output ready
    );
endinterface

@@ hdl/sph_pressure_force_sum.sv @@
// One-dimensional SPH pressure-force accumulator. Each input transaction is one
// neighbour pair of a source particle; for pairs at distinct positions the
// block evaluates the cubic-spline kernel gradient and adds the pressure
// acceleration and internal energy rate terms to two running sums, all in
// signed Q(WORD_WIDTH-FRAC_BITS).FRAC_BITS with saturation. A pair marked
// last_pair produces one output transaction carrying both sums and a sticky
// saturation flag (also set on zero density or zero smoothing length), and the
// sums restart from zero. A small microcoded sequencer drives one shared
// arithmetic unit with short add, subtract, negate and absolute value
// operations, a shift-add multiply and a restoring divide. A pair needs up
// to 5 divides, 11 multiplies and 18 short operations, fewer when the
// distance is at or beyond 1 or 2 smoothing lengths, and none for a pair at
// identical positions. The block takes no new pair while one is in flight;
// a finished result waits in the output register while the next pair is
// already being worked on, and only a second last pair stalls until the
// first result is taken.
module sph_pressure_force_sum
    import sphpf_pkg::*;
#(
    parameter int WORD_WIDTH = 48,
    parameter int FRAC_BITS  = 28
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sphpf_pair_if.sink    i_pair,
    sphpf_sum_if.source   o_sum
);
    localparam int W = WORD_WIDTH;
    localparam logic signed [W-1:0] C_ONE  = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [W-1:0] C_TWO  = {{(W-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
    localparam logic signed [W-1:0] C_C075 = {{(W-2){1'b0}}, 2'b11} << (FRAC_BITS - 2);

    t_seq_state r_state, n_state;
    t_step      r_step, n_step;

    // latched pair
    logic signed [W-1:0] r_sp, r_sv, r_np, r_nv;
    logic [W-2:0]        r_spr, r_srho, r_h, r_npr, r_nrho, r_m;
    logic                r_last;

    // working registers
    logic signed [W-1:0] r_d, r_q, r_t, r_s, r_b, r_poly, r_sigma, r_g;
    logic signed [W-1:0] r_ps, r_pn, r_at, r_et, r_acc, r_en;
    logic                r_flag, r_sat_seen;

    // output register
    logic                r_out_valid;
    logic signed [W-1:0] r_out_acc, r_out_en;
    logic                r_out_sat;

    t_uop                w_uop;
    t_alu_req            w_req;
    t_alu_rsp            w_rsp;
    logic signed [W-1:0] w_opa, w_opb, w_res;
    logic                w_accept, w_emit, w_done;

    sphpf_alu #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_rsp   (w_rsp),
        .o_res   (w_res)
    );

    assign w_uop = f_uop(r_step);

    // operand select
    always_comb begin
        case (w_uop.sa)
            REG_SP:    w_opa = r_sp;
            REG_SV:    w_opa = r_sv;
            REG_SPR:   w_opa = {1'b0, r_spr};
            REG_SRHO:  w_opa = {1'b0, r_srho};
            REG_H:     w_opa = {1'b0, r_h};
            REG_NP:    w_opa = r_np;
            REG_NV:    w_opa = r_nv;
            REG_NPR:   w_opa = {1'b0, r_npr};
            REG_NRHO:  w_opa = {1'b0, r_nrho};
            REG_M:     w_opa = {1'b0, r_m};
            REG_D:     w_opa = r_d;
            REG_Q:     w_opa = r_q;
            REG_T:     w_opa = r_t;
            REG_S:     w_opa = r_s;
            REG_B:     w_opa = r_b;
            REG_POLY:  w_opa = r_poly;
            REG_SIGMA: w_opa = r_sigma;
            REG_G:     w_opa = r_g;
            REG_PS:    w_opa = r_ps;
            REG_PN:    w_opa = r_pn;
            REG_AT:    w_opa = r_at;
            REG_ET:    w_opa = r_et;
            REG_ACC:   w_opa = r_acc;
            REG_EN:    w_opa = r_en;
            REG_ONE:   w_opa = C_ONE;
            REG_TWO:   w_opa = C_TWO;
            REG_C075:  w_opa = C_C075;
            default:   w_opa = '0;
        endcase
        case (w_uop.sb)
            REG_SP:    w_opb = r_sp;
            REG_SV:    w_opb = r_sv;
            REG_SPR:   w_opb = {1'b0, r_spr};
            REG_SRHO:  w_opb = {1'b0, r_srho};
            REG_H:     w_opb = {1'b0, r_h};
            REG_NP:    w_opb = r_np;
            REG_NV:    w_opb = r_nv;
            REG_NPR:   w_opb = {1'b0, r_npr};
            REG_NRHO:  w_opb = {1'b0, r_nrho};
            REG_M:     w_opb = {1'b0, r_m};
            REG_D:     w_opb = r_d;
            REG_Q:     w_opb = r_q;
            REG_T:     w_opb = r_t;
            REG_S:     w_opb = r_s;
            REG_B:     w_opb = r_b;
            REG_POLY:  w_opb = r_poly;
            REG_SIGMA: w_opb = r_sigma;
            REG_G:     w_opb = r_g;
            REG_PS:    w_opb = r_ps;
            REG_PN:    w_opb = r_pn;
            REG_AT:    w_opb = r_at;
            REG_ET:    w_opb = r_et;
            REG_ACC:   w_opb = r_acc;
            REG_EN:    w_opb = r_en;
            REG_ONE:   w_opb = C_ONE;
            REG_TWO:   w_opb = C_TWO;
            REG_C075:  w_opb = C_C075;
            default:   w_opb = '0;
        endcase
    end

    // next state and step
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            SEQ_IDLE: begin
                if (w_accept) begin
                    n_step  = ST_D;
                    // identical positions add nothing
                    n_state = (i_pair.src_position == i_pair.nbr_position) ?
                              SEQ_FINISH : SEQ_ISSUE;
                end
            end
            SEQ_ISSUE: n_state = SEQ_WAIT;
            SEQ_WAIT: begin
                if (w_done) begin
                    n_state = SEQ_ISSUE;
                    case (r_step)
                        // at or beyond two smoothing lengths the gradient is zero
                        ST_Q:    n_step = (w_res >= C_TWO) ? ST_SRSQ : ST_A;
                        // the inner polynomial term only applies below one
                        ST_POLY: n_step = (r_q >= C_ONE) ? ST_H2 : ST_B;
                        // flip both terms only for a negative separation
                        ST_ET:   n_step = r_d[W-1] ? ST_ATN : ST_ACC;
                        ST_EN:   n_state = SEQ_FINISH;
                        default: n_step = t_step'(r_step + 6'd1);
                    endcase
                end
            end
            SEQ_FINISH: begin
                if (!r_last || !r_out_valid || o_sum.ready) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // handshake and control outputs
    always_comb begin
        i_pair.ready   = (r_state == SEQ_IDLE) && i_rst_n;
        w_accept       = i_pair.valid && (r_state == SEQ_IDLE) && i_rst_n;
        w_req.start    = (r_state == SEQ_ISSUE);
        w_req.op       = w_uop.op;
        w_done         = (r_state == SEQ_WAIT) && w_rsp.done;
        w_emit         = (r_state == SEQ_FINISH) && r_last && (!r_out_valid || o_sum.ready);
        o_sum.valid        = r_out_valid;
        o_sum.acceleration = r_out_acc;
        o_sum.energy_rate  = r_out_en;
        o_sum.saturated    = r_out_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_step      <= ST_D;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_en        <= '0;
            r_sat_seen  <= 1'b0;
            r_flag      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;

            if (w_accept) begin
                r_sp   <= i_pair.src_position;
                r_sv   <= i_pair.src_velocity;
                r_spr  <= i_pair.src_pressure;
                r_srho <= i_pair.src_density;
                r_h    <= i_pair.smoothing_length;
                r_np   <= i_pair.nbr_position;
                r_nv   <= i_pair.nbr_velocity;
                r_npr  <= i_pair.nbr_pressure;
                r_nrho <= i_pair.nbr_density;
                r_m    <= i_pair.nbr_mass;
                r_last <= i_pair.last_pair;
                r_flag <= 1'b0;
            end

            if (w_done) begin
                r_flag <= r_flag | w_rsp.sat;
                case (w_uop.dst)
                    REG_D:     r_d     <= w_res;
                    REG_Q:     r_q     <= w_res;
                    REG_T:     r_t     <= w_res;
                    REG_S:     r_s     <= w_res;
                    REG_B:     r_b     <= w_res;
                    REG_POLY:  r_poly  <= w_res;
                    REG_SIGMA: r_sigma <= w_res;
                    REG_G:     r_g     <= w_res;
                    REG_PS:    r_ps    <= w_res;
                    REG_PN:    r_pn    <= w_res;
                    REG_AT:    r_at    <= w_res;
                    REG_ET:    r_et    <= w_res;
                    REG_ACC:   r_acc   <= w_res;
                    REG_EN:    r_en    <= w_res;
                    default: begin
                    end
                endcase
                if (r_step == ST_Q && w_res >= C_TWO) begin
                    r_g <= '0;
                end
            end

            // hold a waiting result until taken, load a fresh one on emit
            r_out_valid <= w_emit | (r_out_valid & ~o_sum.ready);

            if (r_state == SEQ_FINISH && !r_last) begin
                r_sat_seen <= r_sat_seen | r_flag;
            end

            // hand the sums to the output register and restart them
            if (w_emit) begin
                r_out_acc   <= r_acc;
                r_out_en    <= r_en;
                r_out_sat   <= r_sat_seen | r_flag;
                r_acc       <= '0;
                r_en        <= '0;
                r_sat_seen  <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/sphpf_alu.sv @@
module sphpf_alu
    import sphpf_pkg::*;
#(
    parameter int WORD_WIDTH = 48,
    parameter int FRAC_BITS  = 28
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_alu_req                     i_req,
    input  logic signed [WORD_WIDTH-1:0] i_a,
    input  logic signed [WORD_WIDTH-1:0] i_b,
    output t_alu_rsp                     o_rsp,
    output logic signed [WORD_WIDTH-1:0] o_res
);
    localparam int W  = WORD_WIDTH;
    localparam int NB = WORD_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    t_alu_state r_state, n_state;
    t_alu_op    r_op;
    logic [CW-1:0]       r_cnt;
    logic                r_neg;
    logic [W-1:0]        r_ma;
    logic [2*W-1:0]      r_prod;
    logic [W-1:0]        r_rem;
    logic [NB-1:0]       r_num;
    logic [NB-1:0]       r_quo;
    logic signed [W-1:0] r_res;
    logic                r_sat;

    logic signed [W:0]   w_sum;
    logic                w_ovf;
    logic signed [W-1:0] w_clamp;
    logic [W-1:0]        w_amag, w_bmag;
    logic [W:0]          w_pup;
    logic [W:0]          w_rem2;
    logic [W:0]          w_rdiff;
    logic                w_ge;
    logic [2*W-1:0]      w_fmag, w_lim;
    logic                w_fsat;
    logic [W-1:0]        w_fm;

    // combinational add, subtract, negate and absolute value with clamping
    always_comb begin
        case (i_req.op)
            OP_ADD:  w_sum = {i_a[W-1], i_a} + {i_b[W-1], i_b};
            OP_SUB:  w_sum = {i_a[W-1], i_a} - {i_b[W-1], i_b};
            OP_NEG:  w_sum = -{i_a[W-1], i_a};
            OP_ABS:  w_sum = i_a[W-1] ? -{i_a[W-1], i_a} : {i_a[W-1], i_a};
            default: w_sum = '0;
        endcase
        w_ovf   = w_sum[W] ^ w_sum[W-1];
        w_clamp = w_ovf ? (w_sum[W] ? VMIN : VMAX) : w_sum[W-1:0];
        w_amag  = i_a[W-1] ? ({W{1'b0}} - i_a) : i_a;
        w_bmag  = i_b[W-1] ? ({W{1'b0}} - i_b) : i_b;
    end

    always_comb begin
        w_pup   = {1'b0, r_prod[2*W-1:W]} + (r_prod[0] ? {1'b0, r_ma} : {(W+1){1'b0}});
        w_rem2  = {r_rem, r_num[NB-1]};
        w_rdiff = w_rem2 - {1'b0, r_ma};
        w_ge    = w_rem2 >= {1'b0, r_ma};
        w_fmag  = (r_op == OP_MUL) ? (r_prod >> FRAC_BITS) : {{(2*W-NB){1'b0}}, r_quo};
        w_lim   = {{W{1'b0}}, r_neg, {(W-1){~r_neg}}};
        w_fsat  = w_fmag > w_lim;
        w_fm    = w_fsat ? w_lim[W-1:0] : w_fmag[W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == OP_MUL) begin
                        n_state = ALU_MUL;
                    end else if (i_req.op == OP_DIV && i_b != '0) begin
                        n_state = ALU_DIV;
                    end else begin
                        n_state = ALU_DONE;
                    end
                end
            end
            ALU_MUL:  if (r_cnt == CW'(W - 1)) n_state = ALU_FIN;
            ALU_DIV:  if (r_cnt == CW'(NB - 1)) n_state = ALU_FIN;
            ALU_FIN:  n_state = ALU_DONE;
            ALU_DONE: n_state = ALU_IDLE;
            default:  n_state = ALU_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == ALU_DONE);
        o_rsp.sat  = r_sat;
        o_res      = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ALU_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    r_op  <= i_req.op;
                    r_cnt <= '0;
                    r_neg <= i_a[W-1] ^ i_b[W-1];
                    if (i_req.op == OP_MUL) begin
                        r_ma   <= w_amag;
                        r_prod <= {{W{1'b0}}, w_bmag};
                    end else if (i_req.op == OP_DIV) begin
                        // zero divisor: full scale with the sign of the dividend
                        r_res <= i_a[W-1] ? VMIN : VMAX;
                        r_sat <= 1'b1;
                        r_ma  <= w_bmag;
                        r_num <= {w_amag, {FRAC_BITS{1'b0}}};
                        r_rem <= '0;
                        r_quo <= '0;
                    end else begin
                        r_res <= w_clamp;
                        r_sat <= w_ovf;
                    end
                end
            end
            ALU_MUL: begin
                r_prod <= {w_pup, r_prod[W-1:1]};
                r_cnt  <= r_cnt + 1'b1;
            end
            ALU_DIV: begin
                r_rem <= w_ge ? w_rdiff[W-1:0] : w_rem2[W-1:0];
                r_quo <= {r_quo[NB-2:0], w_ge};
                r_num <= {r_num[NB-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            ALU_FIN: begin
                r_res <= r_neg ? ({W{1'b0}} - w_fm) : w_fm;
                r_sat <= w_fsat;
            end
            default: begin
            end
        endcase
    end

endmodule
